[rtl/core/cmpow_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpow_pkg
// Shared types, constants and residue helpers for the code point modular
// power core. The modulus 1114112 is 17 * 2^16, so the datapath works on the
// two residues separately and joins them at the end.
// ----------------------------------------------------------------------------
package cmpow_pkg;

    // Field widths.
    localparam int CP_W     = 21;
    localparam int CP_BYTES = 3;
    localparam int SCAL_W   = 64;
    localparam int EXP_W    = 63;
    localparam int LO_W     = 16;
    localparam int R17_W    = 5;

    // Configuration register indexes.
    localparam logic [0:0] REG_MODE   = 1'b0;
    localparam logic [0:0] REG_SCALAR = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } t_pow_ctl;

    // Reduces a value below 512 modulo 17, using 256 = 1 and 16 = -1 (mod 17).
    function automatic logic [R17_W-1:0] red17_9(input logic [8:0] x);
        logic [5:0] t;
        t = 6'd17 + {5'd0, x[8]} + {2'd0, x[3:0]} - {2'd0, x[7:4]};
        if (t >= 6'd17) begin
            t = t - 6'd17;
        end
        return t[R17_W-1:0];
    endfunction

    // Reduces a 16-bit value modulo 17 by alternating sums of nibbles.
    function automatic logic [R17_W-1:0] red17_16(input logic [15:0] x);
        logic [6:0] t;
        t = 7'd34 + {3'd0, x[3:0]} + {3'd0, x[11:8]}
            - {3'd0, x[7:4]} - {3'd0, x[15:12]};
        if (t >= 7'd17) begin
            t = t - 7'd17;
        end
        if (t >= 7'd17) begin
            t = t - 7'd17;
        end
        if (t >= 7'd17) begin
            t = t - 7'd17;
        end
        return t[R17_W-1:0];
    endfunction

    // Reduces a 32-bit value modulo 17: bytes add up since 256 = 1 (mod 17).
    function automatic logic [R17_W-1:0] red17_32(input logic [31:0] x);
        logic [9:0] s;
        logic [8:0] f;
        s = {2'd0, x[7:0]} + {2'd0, x[15:8]} + {2'd0, x[23:16]} + {2'd0, x[31:24]};
        f = {7'd0, s[9:8]} + {1'b0, s[7:0]};
        return red17_9(f);
    endfunction

endpackage

[rtl/core/cmpow_exp_sreg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpow_exp_sreg
// Exponent shift register. It presents one exponent bit per cycle while the
// step command is set, least significant first, and flags when no set bits remain.
// ----------------------------------------------------------------------------
module cmpow_exp_sreg
    import cmpow_pkg::*;
(
    input  logic             i_clk,
    input  t_pow_ctl         i_ctl,
    input  logic [EXP_W-1:0] i_exp,
    output logic             o_bit,
    output logic             o_done
);

    logic [EXP_W-1:0] r_exp;
    logic [EXP_W-1:0] n_exp;

    // Load a new exponent or shift one bit out.
    always_comb begin
        n_exp = r_exp;
        if (i_ctl.load) begin
            n_exp = i_exp;
        end else if (i_ctl.step) begin
            n_exp = {1'b0, r_exp[EXP_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
    end

    assign o_bit  = r_exp[0];
    assign o_done = (r_exp == '0);

endmodule

[rtl/core/cmpow_pow_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpow_pow_unit
// Square-and-multiply step unit. Each step squares the running base and,
// when the exponent bit is set, multiplies it into the accumulator, in both
// the mod 2^16 and the mod 17 residue channels.
// ----------------------------------------------------------------------------
module cmpow_pow_unit
    import cmpow_pkg::*;
(
    input  logic             i_clk,
    input  t_pow_ctl         i_ctl,
    input  logic             i_bit,
    input  logic [LO_W-1:0]  i_base_lo,
    input  logic [R17_W-1:0] i_base_17,
    output logic [LO_W-1:0]  o_acc_lo,
    output logic [R17_W-1:0] o_acc_17
);

    logic [LO_W-1:0]  r_sq_lo;
    logic [LO_W-1:0]  r_acc_lo;
    logic [R17_W-1:0] r_sq_17;
    logic [R17_W-1:0] r_acc_17;
    logic [LO_W-1:0]  n_sq_lo;
    logic [LO_W-1:0]  n_acc_lo;
    logic [R17_W-1:0] n_sq_17;
    logic [R17_W-1:0] n_acc_17;
    logic [2*LO_W-1:0]  w_sq_lo_p;
    logic [2*LO_W-1:0]  w_mul_lo_p;
    logic [2*R17_W-1:0] w_sq_17_p;
    logic [2*R17_W-1:0] w_mul_17_p;

    // Products; only the low half matters for the power-of-two channel.
    assign w_sq_lo_p  = r_sq_lo * r_sq_lo;
    assign w_mul_lo_p = r_acc_lo * r_sq_lo;
    assign w_sq_17_p  = r_sq_17 * r_sq_17;
    assign w_mul_17_p = r_acc_17 * r_sq_17;

    // Next base and accumulator values.
    always_comb begin
        n_sq_lo  = r_sq_lo;
        n_acc_lo = r_acc_lo;
        n_sq_17  = r_sq_17;
        n_acc_17 = r_acc_17;
        if (i_ctl.load) begin
            n_sq_lo  = i_base_lo;
            n_sq_17  = i_base_17;
            n_acc_lo = LO_W'(1);
            n_acc_17 = R17_W'(1);
        end else if (i_ctl.step) begin
            n_sq_lo = w_sq_lo_p[LO_W-1:0];
            n_sq_17 = red17_9(w_sq_17_p[8:0]);
            if (i_bit) begin
                n_acc_lo = w_mul_lo_p[LO_W-1:0];
                n_acc_17 = red17_9(w_mul_17_p[8:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_lo  <= n_sq_lo;
        r_acc_lo <= n_acc_lo;
        r_sq_17  <= n_sq_17;
        r_acc_17 <= n_acc_17;
    end

    assign o_acc_lo = r_acc_lo;
    assign o_acc_17 = r_acc_17;

endmodule

[rtl/core/cmpow_crt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpow_crt
// Residue recombination. Joins the mod 2^16 and mod 17 residues into the
// value modulo 1114112; since 2^16 = 1 (mod 17) the upper digit is simply
// the difference of the two residues modulo 17.
// ----------------------------------------------------------------------------
module cmpow_crt
    import cmpow_pkg::*;
(
    input  logic [LO_W-1:0]  i_acc_lo,
    input  logic [R17_W-1:0] i_acc_17,
    output logic [CP_W-1:0]  o_value
);

    logic [R17_W-1:0] w_lo_17;
    logic [5:0]       w_diff;
    logic [R17_W-1:0] w_hi;

    // Upper digit k with k + lo = acc_17 (mod 17).
    assign w_lo_17 = red17_16(i_acc_lo);
    assign w_diff  = 6'd17 + {1'b0, i_acc_17} - {1'b0, w_lo_17};
    assign w_hi    = (w_diff >= 6'd17) ? R17_W'(w_diff - 6'd17) : w_diff[R17_W-1:0];

    assign o_value = {w_hi, i_acc_lo};

endmodule

[rtl/core/codepoint_modular_power_core.sv]
`timescale 1ns / 1ps
// An input word loads the exponent register, which then yields one bit per
// cycle to the square-and-multiply unit until no set bits remain; the
// exponent is 0 to 63 bits long. Items are handled one at a time, so a new word
// is taken only after the last result has been written to the output register.
// Reset (synchronous, active low) clears the controller and the output valid,
// and sets power mode with a scalar of one.
// ----------------------------------------------------------------------------
// codepoint_modular_power_core
// Raises a code point to a configured scalar, or the scalar to a code point,
// modulo 1114112, by binary square-and-multiply on split residues.
// ----------------------------------------------------------------------------
module codepoint_modular_power_core
    import cmpow_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_addr,
    input  logic [SCAL_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [8*CP_BYTES-1:0] i_s_axis_tdata,  // [20:0] code_point
    // Output stream.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [8*CP_BYTES-1:0] o_m_axis_tdata   // [20:0] result_code
);

    t_state             r_state;
    t_state             n_state;
    logic               r_mode;
    logic [SCAL_W-1:0]  r_scalar;
    logic               r_neg;
    logic               n_neg;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [CP_W-1:0]    r_out_data;
    logic [CP_W-1:0]    n_out_data;

    t_pow_ctl           w_ctl;
    logic               w_accept;
    logic               w_out_free;
    logic [CP_W-1:0]    w_cp;
    logic [31:0]        w_base;
    logic [EXP_W-1:0]   w_exp;
    logic               w_bit;
    logic               w_done;
    logic [LO_W-1:0]    w_acc_lo;
    logic [R17_W-1:0]   w_acc_17;
    logic [CP_W-1:0]    w_value;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_scalar <= SCAL_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:   r_mode   <= i_cfg_wdata[0];
                REG_SCALAR: r_scalar <= i_cfg_wdata;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    // Operand selection for the incoming word.
    assign w_cp     = i_s_axis_tdata[CP_W-1:0];
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (r_mode) begin
            w_base = r_scalar[31:0];
            w_exp  = EXP_W'(w_cp);
            n_neg  = 1'b0;
        end else begin
            w_base = 32'(w_cp);
            n_neg  = r_scalar[SCAL_W-1];
            w_exp  = n_neg ? '0 : r_scalar[EXP_W-1:0];
        end
    end

    // Controller: next state, datapath commands and output register.
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state     = r_state;
        w_ctl       = '0;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_ctl.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_done) begin
                    n_state = ST_FIN;
                end else begin
                    w_ctl.step = 1'b1;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_neg ? '0 : w_value;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (w_accept) begin
            r_neg <= n_neg;
        end
    end

    // Exponent bits, one per cycle.
    cmpow_exp_sreg u_exp_sreg (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_exp  (w_exp),
        .o_bit  (w_bit),
        .o_done (w_done)
    );

    // Residue square-and-multiply.
    cmpow_pow_unit u_pow_unit (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_bit     (w_bit),
        .i_base_lo (w_base[LO_W-1:0]),
        .i_base_17 (red17_32(w_base)),
        .o_acc_lo  (w_acc_lo),
        .o_acc_17  (w_acc_17)
    );

    // Recombination of the residues.
    cmpow_crt u_crt (
        .i_acc_lo (w_acc_lo),
        .i_acc_17 (w_acc_17),
        .o_value  (w_value)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(8*CP_BYTES-CP_W){1'b0}}, r_out_data};

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for codepoint_modular_power_core. A behavioural
// square-and-multiply predictor works out the expected code point for every
// accepted input word, and a checker compares each output word against the
// oldest prediction. Directed phases cover the register extremes and each
// corner case of the power. Randomised phases, most with bursty idling on both
// stream sides follow them.
// ----------------------------------------------------------------------------
module tb_top
    import cmpow_pkg::*;
();

    localparam longint unsigned CP_MODULUS  = 64'd1114112;
    localparam int              CP_TOP      = 1114111;
    localparam int              CP_ALL_ONES = 2097151;
    localparam int              DRAIN_LIMIT = 4000;
    localparam int              SETTLE_CYCLES = 80;
    localparam int              RAND_PHASES = 12;
    localparam int              RAND_ITEMS  = 84;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [0:0]            i_cfg_addr;
    logic [SCAL_W-1:0]     i_cfg_wdata;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [8*CP_BYTES-1:0] i_s_axis_tdata;  // [20:0] code_point
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [8*CP_BYTES-1:0] o_m_axis_tdata;  // [20:0] result_code

    // Local copy of the configuration registers.
    logic              reflected_copy;
    logic [SCAL_W-1:0] scalar_copy;

    logic [CP_W-1:0] expected_codes[$];
    int              error_count;
    bit              idling_on;
    int              stall_left;

    codepoint_modular_power_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Binary square-and-multiply modulo 1114112, exponent scanned from the LSB.
    function automatic logic [CP_W-1:0] mod_power(input longint unsigned base,
                                                  input longint unsigned expo);
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned e;
        acc = 1;
        sq  = base % CP_MODULUS;
        e   = expo;
        while (e != 0) begin
            if (e[0]) begin
                acc = (acc * sq) % CP_MODULUS;
            end
            sq = (sq * sq) % CP_MODULUS;
            e  = e >> 1;
        end
        return acc[CP_W-1:0];
    endfunction

    // Expected result code for one code point under the current registers.
    function automatic logic [CP_W-1:0] predict_result_code(input logic [CP_W-1:0] cp);
        if (reflected_copy) begin
            return mod_power({32'd0, scalar_copy[31:0]}, {43'd0, cp});
        end else if (scalar_copy[SCAL_W-1]) begin
            return '0;
        end
        return mod_power({43'd0, cp}, {1'b0, scalar_copy[EXP_W-1:0]});
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Writes both registers while the core is idle.
    task automatic set_config(input logic mode, input logic [SCAL_W-1:0] scalar);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_MODE;
        i_cfg_wdata <= {63'd0, mode};
        @(posedge i_clk);
        reflected_copy = mode;
        i_cfg_addr  <= REG_SCALAR;
        i_cfg_wdata <= scalar;
        @(posedge i_clk);
        scalar_copy = scalar;
        i_cfg_we    <= 1'b0;
    endtask

    // Sends one code point word; tvalid stays high on return.
    task automatic send_code_point(input logic [CP_W-1:0] cp);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'd0, cp};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_codes.push_back(predict_result_code(cp));
    endtask

    // Drops tvalid and waits, bounded, for every outstanding result word.
    task automatic end_phase();
        int guard;
        guard = 0;
        i_s_axis_tvalid <= 1'b0;
        while (expected_codes.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_codes.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived",
                                      expected_codes.size()));
            expected_codes.delete();
        end
    endtask

    function automatic logic [CP_W-1:0] pick_code_point();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return 21'd1;
                    2: return CP_W'(CP_TOP);
                    3: return CP_MODULUS[CP_W-1:0];
                    default: return CP_W'(CP_ALL_ONES);
                endcase
            end
            1: return CP_W'($urandom_range(0, 64));
            2, 3: return CP_W'($urandom_range(0, CP_TOP));
            default: return CP_W'($urandom_range(0, CP_ALL_ONES));
        endcase
    endfunction

    function automatic logic [SCAL_W-1:0] pick_scalar();
        logic [SCAL_W-1:0] v;
        int                len;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = 64'($urandom_range(0, 70));
            1: begin
                len = $urandom_range(1, 63);
                v   = v & ((64'd1 << len) - 64'd1);
            end
            2: v[SCAL_W-1] = 1'b1;
            3: v[SCAL_W-1] = 1'b0;
            4: v = 64'h0000_0000_0001_0000 * 64'($urandom_range(0, 65535));
            5: v = {v[63:32], 32'd17 * $urandom_range(0, 1000)};
            6: begin
                case ($urandom_range(0, 3))
                    0: v = 64'h7FFF_FFFF_FFFF_FFFF;
                    1: v = 64'h8000_0000_0000_0000;
                    2: v = '1;
                    default: v = '0;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    // Output side stall generator: bursts with tready low, started at random while idling is on.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Result checker against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        logic [CP_W-1:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_codes.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %0d",
                                          o_m_axis_tdata[CP_W-1:0]));
            end else begin
                want = expected_codes.pop_front();
                if (o_m_axis_tdata[CP_W-1:0] !== want) begin
                    report_mismatch($sformatf("result_code got %0d expected %0d",
                                              o_m_axis_tdata[CP_W-1:0], want));
                end
            end
        end
    end

    // After reset the core returns each code point modulo 1114112: power mode with a scalar of one.
    task automatic test_reset_defaults();
        send_code_point('0);
        send_code_point(21'd1);
        send_code_point(CP_W'(CP_TOP));
        send_code_point(CP_W'(CP_ALL_ONES));
        end_phase();
    endtask

    // Power mode: zero, largest, smallest, minus-one and small exponents.
    task automatic test_power_mode();
        set_config(1'b0, 64'd0);
        send_code_point('0);
        send_code_point(CP_W'(CP_TOP));
        end_phase();
        set_config(1'b0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_code_point(21'd2);
        send_code_point(21'h15_5555);
        end_phase();
        set_config(1'b0, 64'h8000_0000_0000_0000);
        send_code_point(21'd5);
        end_phase();
        set_config(1'b0, '1);
        send_code_point('0);
        end_phase();
        set_config(1'b0, 64'd3);
        send_code_point(21'h0A_AAAA);
        send_code_point(CP_MODULUS[CP_W-1:0]);
        end_phase();
    endtask

    // Reflected mode: zero base, all-ones base, high scalar bits ignored, and a small base.
    task automatic test_reflected_mode();
        set_config(1'b1, 64'd0);
        send_code_point('0);
        send_code_point(21'd5);
        end_phase();
        set_config(1'b1, '1);
        send_code_point(CP_W'(CP_ALL_ONES));
        send_code_point(21'd1);
        end_phase();
        set_config(1'b1, 64'h8000_0000_0001_0011);
        send_code_point(CP_MODULUS[CP_W-1:0]);
        end_phase();
        set_config(1'b1, 64'h7FFF_FFFF_0000_0000);
        send_code_point(21'd3);
        end_phase();
        set_config(1'b1, 64'd2);
        send_code_point(21'd20);
        end_phase();
    endtask

    // Random settings per phase; the final two phases run without idling.
    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            idling_on = (phase < RAND_PHASES - 2);
            set_config(1'($urandom_range(0, 1)), pick_scalar());
            for (n = 0; n < RAND_ITEMS; n++) begin
                send_code_point(pick_code_point());
            end
            end_phase();
        end
    endtask

    initial begin
        error_count     = 0;
        stall_left      = 0;
        idling_on       = 1'b1;
        reflected_copy  = 1'b0;
        scalar_copy     = 64'd1;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= REG_MODE;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_power_mode();
        test_reflected_mode();
        test_random_traffic();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/cmpow_pkg.sv
rtl/core/cmpow_exp_sreg.sv
rtl/core/cmpow_pow_unit.sv
rtl/core/cmpow_crt.sv
rtl/core/codepoint_modular_power_core.sv
sim/tb_top.sv
